[src/three_axis_iir_lowpass_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis smoothing filter
// Shared concurrent check forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_IIR_LOWPASS_MACROS_SVH
`define THREE_AXIS_IIR_LOWPASS_MACROS_SVH

// ante in one cycle implies cons in the next
`define TAIL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// cond holds at every edge out of reset
`define TAIL_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
		else $error("invariant check failed");

`endif

[src/tail_pkg.sv]
// ----------------------------------------------------------------------------
// tail_pkg
// Types and constants shared by the three-axis smoothing filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tail_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ATT_W    = 9;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [ATT_W-1:0]    att_t;

	localparam att_t ATT_RESET = 9'd256;

endpackage

`default_nettype wire

[src/tail_if.sv]
// ----------------------------------------------------------------------------
// tail_if
// Valid/ready channels of the filter: samples in, results out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface tail_sample_if import tail_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample_x;
	sample_t sample_y;
	sample_t sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);
endinterface

interface tail_filtered_if import tail_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t filtered_x;
	sample_t filtered_y;
	sample_t filtered_z;

	modport source (output valid, output filtered_x, output filtered_y,
		output filtered_z, input ready);
	modport sink (input valid, input filtered_x, input filtered_y, input filtered_z,
		output ready);
endinterface

interface tail_cfg_if import tail_pkg::*; ();
	logic valid;
	logic ready;
	att_t attenuation;

	modport source (output valid, output attenuation, input ready);
	modport sink (input valid, input attenuation, output ready);
endinterface

`default_nettype wire

[src/three_axis_iir_lowpass.sv]
// ----------------------------------------------------------------------------
// three_axis_iir_lowpass
// First-order smoothing of x/y/z samples with a shared attenuation gain.
// Input register, then result register, between an accepted sample and its
// result. Throughput: one word per cycle while the result side is not
// stalled; each accumulator update is combinational, one multiply-add deep.
// Reset: accumulators cleared, attenuation set to 256, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_axis_iir_lowpass_macros.svh"

module three_axis_iir_lowpass import tail_pkg::*; #(
	parameter int SHIFT = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	tail_cfg_if.sink        cfg,
	tail_sample_if.sink     samples,
	tail_filtered_if.source filtered
);

	att_t    att_eff;
	logic    advance;
	logic    valid_s1;
	sample_t x_s1, y_s1, z_s1;
	sample_t fx, fy, fz;
	logic    out_valid_q;
	sample_t fx_q, fy_q, fz_q;

	tail_cfg #(.SHIFT(SHIFT)) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.att_eff (att_eff)
	);

	// result register free or being drained
	assign advance       = !out_valid_q || filtered.ready;
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			x_s1 <= samples.sample_x;
			y_s1 <= samples.sample_y;
			z_s1 <= samples.sample_z;
		end
	end

	tail_axis #(.SHIFT(SHIFT)) u_axis_x (
		.clk (clk), .arst_n (arst_n), .en (valid_s1 && advance),
		.sample (x_s1), .att (att_eff), .filtered (fx)
	);

	tail_axis #(.SHIFT(SHIFT)) u_axis_y (
		.clk (clk), .arst_n (arst_n), .en (valid_s1 && advance),
		.sample (y_s1), .att (att_eff), .filtered (fy)
	);

	tail_axis #(.SHIFT(SHIFT)) u_axis_z (
		.clk (clk), .arst_n (arst_n), .en (valid_s1 && advance),
		.sample (z_s1), .att (att_eff), .filtered (fz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			fx_q <= fx;
			fy_q <= fy;
			fz_q <= fz;
		end
	end

	assign filtered.valid      = out_valid_q;
	assign filtered.filtered_x = fx_q;
	assign filtered.filtered_y = fy_q;
	assign filtered.filtered_z = fz_q;

	`TAIL_ASSERT_NEXT(a_stage_moves, clk, arst_n, valid_s1 && advance, out_valid_q)
	`TAIL_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && !advance, valid_s1)
	`TAIL_ASSERT_ALWAYS(a_att_range, clk, arst_n, att_eff != '0 && int'(att_eff) <= (1 << SHIFT))

endmodule

`default_nettype wire

[src/tail_cfg.sv]
// ----------------------------------------------------------------------------
// tail_cfg
// Attenuation register and its clamp to 1..2^SHIFT, or 1..2^ATT_W-1 if wider.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_cfg import tail_pkg::*; #(
	parameter int SHIFT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	tail_cfg_if.sink   cfg,
	output att_t       att_eff
);

	// upper bound; 2^SHIFT only bites while it fits in the register
	localparam int ATT_MAX = (SHIFT >= ATT_W) ? ((1 << ATT_W) - 1) : (1 << SHIFT);

	att_t att_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= ATT_RESET;
		end else if (cfg.valid) begin
			att_q <= cfg.attenuation;
		end
	end

	always_comb begin
		if (att_q == '0) begin
			att_eff = att_t'(1);
		end else if (att_q > att_t'(ATT_MAX)) begin
			att_eff = att_t'(ATT_MAX);
		end else begin
			att_eff = att_q;
		end
	end

endmodule

`default_nettype wire

[src/tail_axis.sv]
// ----------------------------------------------------------------------------
// tail_axis
// One axis: scaled accumulator, multiply-add update, rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tail_axis import tail_pkg::*; #(
	parameter int SHIFT = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  sample_t sample,
	input  att_t    att,
	output sample_t filtered
);

	localparam int ACC_W  = SHIFT + SAMPLE_W + 1;
	localparam int DIFF_W = ACC_W + 1;
	localparam int STEP_W = DIFF_W - SHIFT;
	localparam int PROD_W = STEP_W + ATT_W + 1;
	localparam int SUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
	localparam int HI_W   = ACC_W - SHIFT;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_nxt;
	logic signed [DIFF_W-1:0] scaled;
	logic signed [DIFF_W-1:0] diff;
	logic signed [STEP_W-1:0] step;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W-1:0]  sum;
	logic signed [HI_W:0]     rounded;

	assign scaled = {{(DIFF_W - SAMPLE_W - SHIFT){sample[SAMPLE_W-1]}}, sample,
		{SHIFT{1'b0}}};
	assign diff   = scaled - {acc_q[ACC_W-1], acc_q};
	// floor shift of the difference
	assign step   = diff[DIFF_W-1:SHIFT];
	assign prod   = step * $signed({1'b0, att});
	assign sum    = SUM_W'(acc_q) + SUM_W'(prod);
	// accumulator wraps at its width
	assign acc_nxt = sum[ACC_W-1:0];

	// round half up on bit SHIFT-1
	assign rounded = {acc_nxt[ACC_W-1], acc_nxt[ACC_W-1:SHIFT]}
		+ (HI_W + 1)'(acc_nxt[SHIFT-1]);

	always_comb begin
		if (rounded[HI_W:SAMPLE_W-1] == '0 || rounded[HI_W:SAMPLE_W-1] == '1) begin
			filtered = rounded[SAMPLE_W-1:0];
		end else if (rounded[HI_W]) begin
			filtered = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			filtered = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= acc_nxt;
		end
	end

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-axis smoothing filter. Samples, results
// and attenuation writes go over valid/ready channels with random gaps and
// stalls on both sides. Each accepted sample word is run through a local
// model of the per-axis accumulators, and every result word is compared
// field by field with the oldest pending prediction. A short directed table
// comes first, then gain phases with runs of random, held, jittered and
// swinging samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import tail_pkg::*;

	localparam int SHIFT        = 8;
	localparam int ACC_W        = SHIFT + 17;
	localparam int FULL_GAIN    = 1 << SHIFT;
	localparam int PHASES       = 10;
	localparam int PHASE_WORDS  = 75;
	localparam int STUCK_LIMIT  = 200;
	localparam int DRAIN_CYCLES = 8;

	localparam sample_t S_MAX = 16'sh7FFF;
	localparam sample_t S_MIN = 16'sh8000;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} axes_t;

	typedef struct {
		bit    wr_att;
		att_t  att;
		axes_t in;
		bit    known;
		axes_t exp;
	} dir_row_t;

	typedef enum int {RUN_NOISE, RUN_HOLD, RUN_JITTER, RUN_SWING} run_kind_t;

	logic clk;
	logic arst_n;

	tail_cfg_if      cfg_bus ();
	tail_sample_if   smp_bus ();
	tail_filtered_if flt_bus ();

	three_axis_iir_lowpass #(.SHIFT(SHIFT)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_bus),
		.samples  (smp_bus),
		.filtered (flt_bus)
	);

	// model state
	logic signed [ACC_W-1:0] acc_state [3] = '{default: '0};
	att_t                    att_reg       = ATT_RESET;

	axes_t    want_q [$];
	dir_row_t dir_tbl [$];
	int       err_count    = 0;
	int       results_seen = 0;
	int       stuck_cycles = 0;
	bit       src_gapless  = 1'b0;
	bit       sink_gapless = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sample_t smooth_axis(int idx, sample_t s, longint gain);
		longint                  scaled;
		longint                  diff;
		longint                  nxt;
		longint                  rounded;
		logic signed [ACC_W-1:0] wrapped;
		scaled  = longint'(s) * FULL_GAIN;
		diff    = scaled - longint'(acc_state[idx]);
		// floor shift on the difference, so a falling input can overshoot
		nxt     = longint'(acc_state[idx]) + (diff >>> SHIFT) * gain;
		wrapped = nxt[ACC_W-1:0];
		acc_state[idx] = wrapped;
		rounded = longint'(wrapped) >>> SHIFT;
		if (wrapped[SHIFT-1])
			rounded++;
		if (rounded > longint'(S_MAX))
			return S_MAX;
		if (rounded < longint'(S_MIN))
			return S_MIN;
		return sample_t'(rounded);
	endfunction

	function automatic axes_t smooth_word(axes_t w);
		longint gain;
		axes_t  r;
		if (att_reg == '0)
			gain = 1;
		else if (att_reg > FULL_GAIN)
			gain = FULL_GAIN;
		else
			gain = longint'(att_reg);
		r.x = smooth_axis(0, w.x, gain);
		r.y = smooth_axis(1, w.y, gain);
		r.z = smooth_axis(2, w.z, gain);
		return r;
	endfunction

	function automatic dir_row_t att_row(att_t a);
		dir_row_t r;
		r        = '{default: '0};
		r.wr_att = 1'b1;
		r.att    = a;
		return r;
	endfunction

	function automatic dir_row_t sample_row(axes_t in);
		dir_row_t r;
		r    = '{default: '0};
		r.in = in;
		return r;
	endfunction

	function automatic dir_row_t known_row(axes_t in, axes_t exp);
		dir_row_t r;
		r       = '{default: '0};
		r.in    = in;
		r.known = 1'b1;
		r.exp   = exp;
		return r;
	endfunction

	function automatic sample_t pick_level();
		case ($urandom_range(0, 3))
			0: return S_MAX;
			1: return S_MIN;
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_axis(string name, sample_t got, sample_t want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s: got %0d want %0d",
				results_seen, name, got, want));
	endtask

	task automatic check_word(axes_t got);
		axes_t want;
		results_seen++;
		if (want_q.size() == 0) begin
			report_mismatch($sformatf("word %0d: result with nothing pending", results_seen));
		end else begin
			want = want_q.pop_front();
			check_axis("filtered_x", got.x, want.x);
			check_axis("filtered_y", got.y, want.y);
			check_axis("filtered_z", got.z, want.z);
		end
	endtask

	// entered and left at a falling edge
	task automatic send_word(axes_t w, bit known, axes_t exp);
		int    gap;
		axes_t pred;
		gap = src_gapless ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			smp_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		smp_bus.valid    = 1'b1;
		smp_bus.sample_x = w.x;
		smp_bus.sample_y = w.y;
		smp_bus.sample_z = w.z;
		do @(posedge clk); while (!smp_bus.ready);
		pred = smooth_word(w);
		want_q.push_back(known ? exp : pred);
		@(negedge clk);
	endtask

	// gain changes only with the pipe drained
	task automatic write_att(att_t a);
		smp_bus.valid = 1'b0;
		wait (want_q.size() == 0);
		@(negedge clk);
		cfg_bus.valid       = 1'b1;
		cfg_bus.attenuation = a;
		do @(posedge clk); while (!cfg_bus.ready);
		att_reg = a;
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && flt_bus.valid && flt_bus.ready)
			check_word(axes_t'{flt_bus.filtered_x, flt_bus.filtered_y, flt_bus.filtered_z});
	end

	always @(posedge clk) begin
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else if (!arst_n || (smp_bus.valid && smp_bus.ready)
				|| (flt_bus.valid && flt_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side: random stall per word, with gapless stretches now and then
	initial begin
		int stall;
		flt_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				sink_gapless = !sink_gapless;
			stall = sink_gapless ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				flt_bus.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			flt_bus.ready = 1'b1;
			do @(posedge clk); while (!flt_bus.valid);
			@(negedge clk);
		end
	end

	initial begin
		att_t      phase_att [PHASES];
		run_kind_t kind;
		axes_t     base;
		axes_t     w;
		int        left;
		int        run;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.attenuation = ATT_RESET;
		smp_bus.valid       = 1'b0;
		smp_bus.sample_x    = '0;
		smp_bus.sample_y    = '0;
		smp_bus.sample_z    = '0;

		// out of reset the gain is full, so each output equals its input
		dir_tbl = '{
			known_row('{16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0}),
			known_row('{S_MAX, S_MIN, 16'sd1}, '{S_MAX, S_MIN, 16'sd1}),
			known_row('{S_MIN, S_MAX, -16'sd1}, '{S_MIN, S_MAX, -16'sd1}),
			known_row('{16'sh5555, 16'shAAAA, -16'sd256},
				'{16'sh5555, 16'shAAAA, -16'sd256}),
			att_row(9'd1),
			sample_row('{S_MAX, S_MIN, 16'sd0}),
			sample_row('{S_MAX, S_MIN, 16'sd0}),
			// zero gain acts as one
			att_row(9'd0),
			sample_row('{S_MIN, S_MAX, 16'sd12345}),
			sample_row('{S_MIN, S_MAX, 16'sd12345}),
			// above full scale clamps to full gain
			att_row(9'd511),
			sample_row('{S_MAX, S_MIN, -16'sd12345}),
			sample_row('{S_MAX, S_MIN, -16'sd12345}),
			att_row(9'd257),
			sample_row('{S_MIN, S_MIN, S_MIN}),
			sample_row('{S_MAX, S_MAX, S_MAX}),
			// large gain toward the rails: floor overshoot and output clipping
			att_row(9'd200),
			sample_row('{S_MIN, -16'sd32767, S_MAX}),
			sample_row('{S_MIN, -16'sd32767, S_MAX}),
			sample_row('{S_MIN, -16'sd32767, S_MAX}),
			att_row(9'd255),
			sample_row('{S_MAX, S_MIN, 16'sd100}),
			sample_row('{S_MAX, S_MIN, 16'sd100}),
			sample_row('{S_MAX, S_MIN, 16'sd100}),
			att_row(9'd128),
			sample_row('{16'sd0, -16'sd1, 16'sd1}),
			sample_row('{16'sd0, -16'sd1, 16'sd1}),
			att_row(9'd256),
			sample_row('{-16'sd1, 16'sd1, 16'sd0})
		};

		phase_att = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd257, 9'd255, 9'd0, 9'd0, 9'd0, 9'd0};
		for (int i = 6; i < PHASES; i++)
			phase_att[i] = att_t'($urandom_range(0, 511));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].wr_att)
				write_att(dir_tbl[i].att);
			else
				send_word(dir_tbl[i].in, dir_tbl[i].known, dir_tbl[i].exp);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_att(phase_att[ph]);
			left = PHASE_WORDS;
			while (left > 0) begin
				run  = $urandom_range(1, 20);
				if (run > left)
					run = left;
				kind        = run_kind_t'($urandom_range(0, 3));
				src_gapless = ($urandom_range(0, 4) == 0);
				base        = '{pick_level(), pick_level(), pick_level()};
				for (int k = 0; k < run; k++) begin
					case (kind)
						RUN_NOISE: w = '{sample_t'($urandom), sample_t'($urandom),
							sample_t'($urandom)};
						RUN_HOLD: w = base;
						RUN_JITTER: begin
							w.x = base.x + sample_t'($urandom_range(0, 32)) - 16'sd16;
							w.y = base.y + sample_t'($urandom_range(0, 32)) - 16'sd16;
							w.z = base.z + sample_t'($urandom_range(0, 32)) - 16'sd16;
						end
						// steps back and forth between the base level and its bitwise inverse
						default: w = k[0] ? ~base : base;
					endcase
					send_word(w, 1'b0, w);
				end
				left -= run;
			end
		end

		smp_bus.valid = 1'b0;
		wait (want_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
